// ----- src/prlt_pkg.sv -----
// Package with the shared types and constants of the pair rate limiter table.
package prlt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 40;
    localparam int TIME_W        = 64;
    localparam int CFG_W         = 32;
    localparam int AGE_SHIFT     = 3;     // sweep age limit is eight intervals
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd30000;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] time_now;
        logic [ADDR_W-1:0] addr_source;
        logic [ADDR_W-1:0] addr_dest;
    } t_request;

    typedef struct packed {
        logic grant;
        logic table_full;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] high_addr;
        logic [ADDR_W-1:0] low_addr;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_entry;
    } t_ram_cmd;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_finish;

endpackage

// ----- src/pair_rate_limiter_table_unit.sv -----
// Top level of the pair rate limiter table: config register, entry RAM, result register.
//
//  channel   direction  handshake                 payload
//  request   in         start, busy               i_req    (t_request)
//  result    out        o_valid (one-cycle strobe) o_result (t_result)
//  config    in         i_cfg_we                  i_cfg_wdata (min_pair_interval)
//
// The result strobe rises after the scan of all TABLE_ENTRIES slots, the
// FINISH state and the result register, and is taken while it shows; the
// single read port of the entry RAM, visited one entry per cycle, sets how
// long a request holds the block. busy drops in the cycle the result
// shows, so the next request may be taken then.
// Synchronous active-low reset clears all valid bits at once; the RAM itself
// needs no clearing pass. The receiver cannot stall: every result is taken.
module pair_rate_limiter_table_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  prlt_pkg::t_request         i_req,
    output logic                       o_valid,
    output prlt_pkg::t_result          o_result,
    input  logic                       i_cfg_we,
    input  logic [prlt_pkg::CFG_W-1:0] i_cfg_wdata
);
    import prlt_pkg::*;

    logic [CFG_W-1:0]   r_min_interval;
    logic               r_valid;
    t_result            r_result;
    t_ram_cmd           ram_cmd;
    t_finish            finish;
    logic [ENTRY_W-1:0] rd_data;

    // Hold the interval; writes must come only while no request is in flight, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_min_interval <= i_cfg_wdata;
        end
    end

    // Entry RAM: one key pair and stamp per slot. Writes happen only in the
    // FINISH state and reads start only after the next request is accepted
    // from idle, so no read can overlap a pending write to the same entry.
    prlt_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.wr_en),
        .i_waddr (ram_cmd.wr_idx),
        .i_wdata (ram_cmd.wr_entry),
        .i_re    (ram_cmd.rd_en),
        .i_raddr (ram_cmd.rd_idx),
        .o_rdata (rd_data)
    );

    // Scan sequencer: lookup, free-slot search, sweep and final decision.
    prlt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_min_interval (r_min_interval),
        .i_rd_data      (rd_data),
        .o_ram_cmd      (ram_cmd),
        .o_finish       (finish)
    );

    // Register the decision and present it for exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= finish.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish.valid) begin
            r_result <= finish.result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_grant_full_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.grant && o_result.table_full))
        else $error("grant and table_full both set");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- src/prlt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module prlt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 144,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/prlt_ctrl.sv -----
// Scan sequencer: walks the entry memory, keeps valid bits, decides each request.
module prlt_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  prlt_pkg::t_request       i_req,
    input  logic [prlt_pkg::CFG_W-1:0] i_min_interval,
    input  logic [prlt_pkg::ENTRY_W-1:0] i_rd_data,
    output prlt_pkg::t_ram_cmd       o_ram_cmd,
    output prlt_pkg::t_finish        o_finish
);
    import prlt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state               r_state, n_state;
    logic                 r_cmd;
    logic [TIME_W-1:0]    r_now;
    logic [ADDR_W-1:0]    r_hi;
    logic [ADDR_W-1:0]    r_lo;
    logic [CNT_W-1:0]     r_rd_cnt;
    logic                 r_chk_vld;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                 r_hit_found;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [TIME_W-1:0]    r_hit_stamp;
    logic                 r_free_found;
    logic [IDX_W-1:0]     r_free_idx;

    t_entry            rd_entry;
    logic              accept;
    logic              issue;
    logic              chk_valid_bit;
    logic              chk_match;
    logic              chk_expired;
    logic [TIME_W-1:0] sweep_limit;
    logic [TIME_W-1:0] hit_age;
    logic              hit_grant;
    logic              scan_done;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign rd_entry = t_entry'(i_rd_data);

    assign issue         = (r_state == S_SCAN) && (r_rd_cnt < CNT_W'(TABLE_ENTRIES));
    assign chk_valid_bit = r_valid[r_chk_idx];
    assign chk_match     = chk_valid_bit && (rd_entry.high_addr == r_hi)
                           && (rd_entry.low_addr == r_lo);
    assign sweep_limit   = {{(TIME_W - CFG_W - AGE_SHIFT){1'b0}}, i_min_interval,
                            {AGE_SHIFT{1'b0}}};
    assign chk_expired   = chk_valid_bit && ((r_now - rd_entry.stamp) >= sweep_limit);
    assign scan_done     = r_chk_vld && (r_chk_idx == LAST_IDX);

    assign hit_age   = r_now - r_hit_stamp;
    assign hit_grant = hit_age >= {{(TIME_W - CFG_W){1'b0}}, i_min_interval};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_SCAN;
            S_SCAN:   if (scan_done) n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory commands and the decision at the end of the scan.
    always_comb begin
        o_ram_cmd                   = '0;
        o_ram_cmd.rd_en             = issue;
        o_ram_cmd.rd_idx            = r_rd_cnt[IDX_W-1:0];
        o_ram_cmd.wr_entry.high_addr = r_hi;
        o_ram_cmd.wr_entry.low_addr  = r_lo;
        o_ram_cmd.wr_entry.stamp     = r_now;
        o_finish                    = '0;
        if (r_state == S_FINISH) begin
            o_finish.valid = 1'b1;
            if (r_cmd == CMD_QUERY) begin
                if (r_hit_found) begin
                    o_finish.result.grant = hit_grant;
                    o_ram_cmd.wr_en       = hit_grant;
                    o_ram_cmd.wr_idx      = r_hit_idx;
                end else if (r_free_found) begin
                    o_finish.result.grant = (i_min_interval == '0);
                    o_ram_cmd.wr_en       = 1'b1;
                    o_ram_cmd.wr_idx      = r_free_idx;
                end else begin
                    o_finish.result.table_full = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_chk_vld    <= 1'b0;
            r_rd_cnt     <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_cnt     <= '0;
                r_chk_vld    <= 1'b0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                r_chk_vld <= issue;
                if (issue) begin
                    r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                end
            end
            if (r_chk_vld && (r_state == S_SCAN)) begin
                if (r_cmd == CMD_SWEEP) begin
                    if (chk_expired) begin
                        r_valid[r_chk_idx] <= 1'b0;
                    end
                end else begin
                    if (chk_match && !r_hit_found) begin
                        r_hit_found <= 1'b1;
                    end
                    if (!chk_valid_bit && !r_free_found) begin
                        r_free_found <= 1'b1;
                    end
                end
            end
            if ((r_state == S_FINISH) && (r_cmd == CMD_QUERY) && !r_hit_found
                && r_free_found) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // Payload registers: request copy, scan index and lookup captures.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_req.command;
            r_now <= i_req.time_now;
            if (i_req.addr_source > i_req.addr_dest) begin
                r_hi <= i_req.addr_source;
                r_lo <= i_req.addr_dest;
            end else begin
                r_hi <= i_req.addr_dest;
                r_lo <= i_req.addr_source;
            end
        end
        if (issue) begin
            r_chk_idx <= r_rd_cnt[IDX_W-1:0];
        end
        if (r_chk_vld && (r_state == S_SCAN) && (r_cmd == CMD_QUERY)) begin
            if (chk_match && !r_hit_found) begin
                r_hit_idx   <= r_chk_idx;
                r_hit_stamp <= rd_entry.stamp;
            end
            if (!chk_valid_bit && !r_free_found) begin
                r_free_idx <= r_chk_idx;
            end
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the pair rate limiter table: directed rows, then random phases.
`timescale 1ns / 100ps

module tb_top;
    import prlt_pkg::*;

    // Watchdog limit in cycles with neither a request nor a result moving.
    localparam int QUIET_LIMIT     = 1000;
    localparam int RESULT_LATENCY  = TABLE_ENTRIES + 3;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_REQUESTS  = 305;
    localparam int PAIR_POOL       = 20;

    localparam t_result VERDICT_DENY  = '{grant: 1'b0, table_full: 1'b0};
    localparam t_result VERDICT_GRANT = '{grant: 1'b1, table_full: 1'b0};
    localparam t_result VERDICT_FULL  = '{grant: 1'b0, table_full: 1'b1};

    typedef enum logic {ROW_REQUEST, ROW_INTERVAL} t_row_kind;

    // One directed row: either a request or an interval write. Rows with
    // typed set carry their verdict; the rest take the predicted one.
    typedef struct {
        t_row_kind          kind;
        t_request           req;
        logic [CFG_W-1:0]   interval;
        bit                 typed;
        t_result            verdict;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_request           i_req = '0;
    logic               o_valid;
    t_result            o_result;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    // Shadow of the block: interval register and the pair table.
    logic [CFG_W-1:0]   interval_model;
    bit                 slot_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  slot_high  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]  slot_low   [TABLE_ENTRIES];
    logic [TIME_W-1:0]  slot_stamp [TABLE_ENTRIES];

    // Verdicts owed by the block, oldest first.
    t_result            verdicts_due [$];
    t_result            verdict_head;
    t_row               directed_rows [$];

    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    int                 burst_left = 0;

    // Random stream state: running clock and the pair pool of the phase.
    logic [TIME_W-1:0]  clock_now;
    logic [ADDR_W-1:0]  pool_a [PAIR_POOL];
    logic [ADDR_W-1:0]  pool_b [PAIR_POOL];

    pair_rate_limiter_table_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Work out the verdict for one accepted request and advance the shadow table.
    // Sweeps drop every entry aged at least eight intervals; queries look the
    // unordered pair up, claim the lowest free slot for a new pair, and grant
    // once the interval has passed since the stamp. Ages wrap modulo 2^64.
    function automatic t_result predict_verdict(input t_request req);
        t_result            verdict;
        logic [TIME_W-1:0]  age_limit;
        logic [ADDR_W-1:0]  hi;
        logic [ADDR_W-1:0]  lo;
        int                 hit;
        int                 free_slot;
        int                 i;
        verdict = VERDICT_DENY;
        if (req.command == CMD_SWEEP) begin
            age_limit = {32'd0, interval_model} << AGE_SHIFT;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_valid[i] && (req.time_now - slot_stamp[i]) >= age_limit) begin
                    slot_valid[i] = 1'b0;
                end
            end
        end else begin
            hi = (req.addr_source > req.addr_dest) ? req.addr_source : req.addr_dest;
            lo = (req.addr_source > req.addr_dest) ? req.addr_dest : req.addr_source;
            hit = -1;
            free_slot = -1;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_valid[i]) begin
                    if (hit < 0 && slot_high[i] == hi && slot_low[i] == lo) begin
                        hit = i;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit < 0 && free_slot < 0) begin
                // Table full: no entry is created for the new pair.
                verdict = VERDICT_FULL;
            end else begin
                if (hit < 0) begin
                    hit = free_slot;
                    slot_valid[hit] = 1'b1;
                    slot_high[hit]  = hi;
                    slot_low[hit]   = lo;
                    slot_stamp[hit] = req.time_now;
                end
                if ((req.time_now - slot_stamp[hit]) >= {32'd0, interval_model}) begin
                    slot_stamp[hit] = req.time_now;
                    verdict = VERDICT_GRANT;
                end
            end
        end
        return verdict;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] word;
        word = {$urandom, $urandom};
        return word[ADDR_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    function automatic t_row request_row(input logic cmd, input logic [TIME_W-1:0] stamp,
                                         input logic [ADDR_W-1:0] a,
                                         input logic [ADDR_W-1:0] b,
                                         input bit typed, input t_result verdict);
        t_row row;
        row.kind     = ROW_REQUEST;
        row.req      = '{command: cmd, time_now: stamp, addr_source: a, addr_dest: b};
        row.interval = '0;
        row.typed    = typed;
        row.verdict  = verdict;
        return row;
    endfunction

    function automatic t_row interval_row(input logic [CFG_W-1:0] value);
        t_row row;
        row.kind     = ROW_INTERVAL;
        row.req      = '0;
        row.interval = value;
        row.typed    = 1'b0;
        row.verdict  = VERDICT_DENY;
        return row;
    endfunction

    // Draw the next random request. Most are queries on the phase's pair pool
    // with the clock stepping around the interval, so grants, refreshes, hits
    // and a full table all show up; sweeps and random noise fill the rest.
    function automatic t_request next_random_request();
        t_request           req;
        logic [TIME_W-1:0]  span;
        int                 pick;
        int                 step_kind;
        int                 k;
        span = {32'd0, interval_model};
        step_kind = $urandom_range(0, 99);
        if (step_kind < 70) begin
            clock_now += (span * $urandom_range(0, 200)) / 100 + $urandom_range(0, 2);
        end else if (step_kind < 88) begin
            clock_now += $urandom_range(0, 1);
        end else begin
            // Jump past the sweep age so entries expire.
            clock_now += (span << AGE_SHIFT) + $urandom_range(0, 3);
        end
        pick = $urandom_range(0, 99);
        req.time_now    = clock_now;
        req.addr_source = rand_addr();
        req.addr_dest   = rand_addr();
        if (pick < 8) begin
            req.command = CMD_SWEEP;
        end else begin
            req.command = CMD_QUERY;
            if (pick < 14) begin
                req.time_now = rand_time();
            end else begin
                k = $urandom_range(0, PAIR_POOL - 1);
                if ($urandom_range(0, 1) == 0) begin
                    req.addr_source = pool_a[k];
                    req.addr_dest   = pool_b[k];
                end else begin
                    req.addr_source = pool_b[k];
                    req.addr_dest   = pool_a[k];
                end
            end
        end
        return req;
    endfunction

    // Present one request and hold it until the block takes it, then queue its verdict.
    // start stays high on return so back-to-back requests keep it raised.
    task automatic issue_request(input t_request req, input bit typed,
                                 input t_result typed_verdict);
        t_result predicted;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = predict_verdict(req);
        verdicts_due.push_back(typed ? typed_verdict : predicted);
    endtask

    // Sender pacing: bursts of random length, random gaps between them.
    // A zero gap runs two bursts together for stretches with no idling.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Drain all outstanding requests, then write the interval while the block is idle.
    task automatic write_interval(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        interval_model = value;
    endtask

    // Result checker: every strobe pops the oldest verdict and compares field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (verdicts_due.size() == 0) begin
                $error("result with no request outstanding: grant=%0b table_full=%0b",
                       o_result.grant, o_result.table_full);
                mismatch_count++;
            end else begin
                verdict_head = verdicts_due.pop_front();
                if (o_result.grant !== verdict_head.grant) begin
                    $error("grant: expected %0b, got %0b", verdict_head.grant, o_result.grant);
                    mismatch_count++;
                end
                if (o_result.table_full !== verdict_head.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           verdict_head.table_full, o_result.table_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request is taken and no result shows.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int             i;
        int             phase;
        int             k;
        logic [CFG_W-1:0] phase_interval;

        // Shadow state after reset: empty table, interval at its reset value.
        interval_model = INTERVAL_RESET;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_high[i]  = '0;
            slot_low[i]   = '0;
            slot_stamp[i] = '0;
        end

        // Directed rows, run at the reset interval of 30000 first.
        // Boundary of the interval, with the pair given in both orders.
        directed_rows.push_back(request_row(CMD_QUERY, 64'd0, 40'd5, 40'd3, 1'b1, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_QUERY, 64'd29999, 40'd3, 40'd5,
                                            1'b1, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_QUERY, 64'd30000, 40'd5, 40'd3,
                                            1'b1, VERDICT_GRANT));
        // Extreme addresses and time, then a query whose age wraps past 2^64.
        directed_rows.push_back(request_row(CMD_QUERY, '1, '1, '0, 1'b1, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_QUERY, 64'd29999, '0, '1, 1'b0, VERDICT_DENY));
        // Pair of equal addresses.
        directed_rows.push_back(request_row(CMD_QUERY, 64'd100, 40'd7, 40'd7,
                                            1'b1, VERDICT_DENY));
        // Fill the remaining slots.
        for (i = 0; i < TABLE_ENTRIES - 3; i++) begin
            directed_rows.push_back(request_row(CMD_QUERY, 64'd200 + i, 40'h10 + i, 40'h20 + i,
                                                1'b0, VERDICT_DENY));
        end
        // New pair with the table full.
        directed_rows.push_back(request_row(CMD_QUERY, 64'd300, 40'd1, 40'd2,
                                            1'b1, VERDICT_FULL));
        // Sweep that frees only the equal-address entry (stamp 100).
        directed_rows.push_back(request_row(CMD_SWEEP, 64'd240150, '0, '0, 1'b1, VERDICT_DENY));
        // New pair takes the freed slot; the next new pair finds the table full again.
        directed_rows.push_back(request_row(CMD_QUERY, 64'd240200, 40'd9, 40'd8,
                                            1'b0, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_QUERY, 64'd240201, 40'd1, 40'd2,
                                            1'b1, VERDICT_FULL));
        // Zero interval: a sweep empties the table and a new pair is granted at once.
        directed_rows.push_back(interval_row('0));
        directed_rows.push_back(request_row(CMD_SWEEP, 64'd0, '1, '1, 1'b1, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_QUERY, 64'd5, 40'd1, 40'd2,
                                            1'b1, VERDICT_GRANT));
        // Largest interval: grant exactly at the interval, sweep exactly at eight.
        directed_rows.push_back(interval_row('1));
        directed_rows.push_back(request_row(CMD_QUERY, 64'h1_0000_0004, 40'd2, 40'd1,
                                            1'b0, VERDICT_DENY));
        directed_rows.push_back(request_row(CMD_SWEEP, 64'h8_FFFF_FFFC, '0, '0,
                                            1'b1, VERDICT_DENY));

        // Hold reset, then release it for good.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed rows.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_INTERVAL) begin
                write_interval(directed_rows[i].interval);
            end else begin
                pace_sender();
                issue_request(directed_rows[i].req, directed_rows[i].typed,
                              directed_rows[i].verdict);
            end
        end

        // Random phases, one interval each; the write at each phase start
        // also makes the sender wait until every verdict has come back.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: phase_interval = INTERVAL_RESET;
                1: phase_interval = '0;
                2: phase_interval = 32'd1;
                3: phase_interval = $urandom_range(2, 5000);
                4: phase_interval = $urandom;
                default: phase_interval = '1;
            endcase
            write_interval(phase_interval);

            // Start the clock either anywhere or just short of wrapping.
            if ($urandom_range(0, 1) == 0) begin
                clock_now = rand_time();
            end else begin
                clock_now = '1 - $urandom_range(0, 500);
            end
            // More pairs than slots, so the table fills unless sweeps clear it.
            for (k = 0; k < PAIR_POOL; k++) begin
                pool_a[k] = rand_addr();
                pool_b[k] = ($urandom_range(0, 7) == 0) ? pool_a[k] : rand_addr();
            end

            repeat (PHASE_REQUESTS) begin
                pace_sender();
                issue_request(next_random_request(), 1'b0, VERDICT_DENY);
            end
        end

        // Drop start, drain the outstanding verdicts, then watch for strays.
        start <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);

        if (mismatch_count == 0 && verdicts_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- pair_rate_limiter_table_unit.f -----
src/prlt_pkg.sv
src/prlt_ram.sv
src/prlt_ctrl.sv
src/pair_rate_limiter_table_unit.sv
test/tb_top.sv
